@@ src/assert_macros.svh @@
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ukp_pkg.sv @@
`timescale 1ns / 1ps
package ukp_pkg;

	typedef enum logic [1:0] {
		ACT_SAMPLE  = 2'd0,
		ACT_READ_UP = 2'd1,
		ACT_READ_RT = 2'd2,
		ACT_SET_RT  = 2'd3
	} action_t;

	localparam logic [63:0] US_PER_SEC = 64'd1000000;
	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [9:0]  NS_PER_US  = 10'd1000;

	// 2^(16*i) mod 10^6 for the 16-bit chunks of a 64-bit difference
	localparam logic [19:0] MOD_K1 = 20'd65536;
	localparam logic [19:0] MOD_K2 = 20'd967296;
	localparam logic [19:0] MOD_K3 = 20'd710656;
	// 2^20 mod 10^6
	localparam logic [19:0] MOD_FOLD = 20'd48576;
	// ceil(2^50 / 10^6), exact quotient for values below 2^30
	localparam logic [30:0] RECIP_M = 31'd1125899907;

	// Item data that rides alongside the remainder pipeline
	typedef struct packed {
		action_t     action;
		logic [63:0] sec;       // uptime seconds as seen by this item
		logic [63:0] set_sec;   // normalized realtime seconds to set
		logic [29:0] set_nsec;  // normalized realtime nanoseconds to set
	} item_t;

endpackage

@@ src/ukp_sample_front.sv @@
`timescale 1ns / 1ps
module ukp_sample_front
	import ukp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        item_valid,
	input  action_t     action,
	input  logic [63:0] sample,
	input  logic [63:0] set_sec,
	input  logic [29:0] set_nsec,
	output logic [63:0] diff,
	output item_t       side
);

	logic [63:0] sec_q;
	logic [63:0] prev_q;
	logic [63:0] mark_q;
	logic        hit;
	logic        ns_over;

	assign hit     = (sample >= mark_q);
	assign diff    = sample - prev_q;
	assign ns_over = (set_nsec >= NS_PER_SEC);

	always_comb begin
		side.action   = action;
		side.sec      = (action == ACT_SAMPLE && hit) ? sec_q + 64'd1 : sec_q;
		side.set_sec  = ns_over ? set_sec + 64'd1 : set_sec;
		side.set_nsec = ns_over ? set_nsec - NS_PER_SEC : set_nsec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= '0;
			prev_q <= '0;
			mark_q <= '0;
		end else if (en && item_valid && action == ACT_SAMPLE) begin
			if (hit) begin
				sec_q  <= sec_q + 64'd1;
				mark_q <= sample + US_PER_SEC;
			end
			prev_q <= sample;
		end
	end

endmodule

@@ src/ukp_mod_us.sv @@
`timescale 1ns / 1ps
module ukp_mod_us
	import ukp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [63:0] diff,
	input  item_t       in_side,
	output logic        out_valid,
	output logic [19:0] rem,
	output item_t       out_side
);

	// Five stages: chunk products, two folds by 2^20, reciprocal quotient, remainder.
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	item_t       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [37:0] sum_s1;
	logic [33:0] fold_s2;
	logic [29:0] val_s3;
	logic [29:0] val_s4;
	logic [9:0]  quo_s4;
	logic [19:0] rem_s5;

	logic [35:0] p1, p2, p3;
	logic [37:0] sum_d;
	logic [37:0] f1;
	logic [33:0] f2;
	logic [60:0] prod;
	logic [29:0] qm;
	logic [29:0] r_full;

	always_comb begin
		p1     = diff[31:16] * MOD_K1;
		p2     = diff[47:32] * MOD_K2;
		p3     = diff[63:48] * MOD_K3;
		sum_d  = {22'b0, diff[15:0]} + {2'b0, p1} + {2'b0, p2} + {2'b0, p3};
		f1     = sum_s1[37:20] * MOD_FOLD;
		f2     = fold_s2[33:20] * MOD_FOLD;
		prod   = val_s3 * RECIP_M;
		qm     = quo_s4 * 20'(US_PER_SEC);
		r_full = val_s4 - qm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			sum_s1  <= sum_d;
			fold_s2 <= f1[33:0] + {14'b0, sum_s1[19:0]};
			val_s3  <= f2[29:0] + {10'b0, fold_s2[19:0]};
			quo_s4  <= prod[59:50];
			val_s4  <= val_s3;
			rem_s5  <= r_full[19:0];
		end
	end

	assign out_valid = vld_s5;
	assign rem       = rem_s5;
	assign out_side  = side_s5;

endmodule

@@ src/ukp_time_acc.sv @@
`timescale 1ns / 1ps
module ukp_time_acc
	import ukp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [19:0]        rem,
	input  item_t              side,
	output logic               out_valid,
	output logic signed [63:0] out_sec,
	output logic [29:0]        out_nsec
);

	logic [29:0] ns_q;
	logic [63:0] off_sec_q;
	logic [29:0] off_ns_q;
	logic        out_valid_q;
	logic [63:0] out_sec_q;
	logic [29:0] out_nsec_q;

	logic [29:0] step;
	logic [30:0] ns_sum;
	logic [29:0] ns_new;
	logic [30:0] rt_sum;
	logic        rt_carry;
	logic [29:0] rt_ns;
	logic [63:0] rt_sec;
	logic        borrow;
	logic [30:0] set_diff;
	logic [29:0] set_ns;
	logic [63:0] set_sec_r;
	logic [63:0] res_sec;
	logic [29:0] res_ns;

	always_comb begin
		step     = {10'b0, rem} * {20'b0, NS_PER_US};
		ns_sum   = {1'b0, ns_q} + {1'b0, step};
		ns_new   = (ns_sum >= {1'b0, NS_PER_SEC}) ? 30'(ns_sum - {1'b0, NS_PER_SEC})
			: ns_sum[29:0];

		rt_sum   = {1'b0, ns_q} + {1'b0, off_ns_q};
		rt_carry = (rt_sum >= {1'b0, NS_PER_SEC});
		rt_ns    = rt_carry ? 30'(rt_sum - {1'b0, NS_PER_SEC}) : rt_sum[29:0];
		rt_sec   = side.sec + off_sec_q + {63'b0, rt_carry};

		borrow    = (side.set_nsec < ns_q);
		set_diff  = borrow ? {1'b0, side.set_nsec} + {1'b0, NS_PER_SEC} - {1'b0, ns_q}
			: {1'b0, side.set_nsec} - {1'b0, ns_q};
		set_ns    = set_diff[29:0];
		set_sec_r = side.set_sec - side.sec - {63'b0, borrow};

		case (side.action)
			ACT_SAMPLE: begin
				res_sec = side.sec;
				res_ns  = ns_new;
			end
			ACT_READ_UP: begin
				res_sec = side.sec;
				res_ns  = ns_q;
			end
			ACT_READ_RT: begin
				res_sec = rt_sec;
				res_ns  = rt_ns;
			end
			ACT_SET_RT: begin
				res_sec = set_sec_r;
				res_ns  = set_ns;
			end
			default: begin
				res_sec = side.sec;
				res_ns  = ns_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q        <= '0;
			off_sec_q   <= '0;
			off_ns_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= in_valid;
			if (in_valid) begin
				if (side.action == ACT_SAMPLE) begin
					ns_q <= ns_new;
				end
				if (side.action == ACT_SET_RT) begin
					off_sec_q <= set_sec_r;
					off_ns_q  <= set_ns;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out_sec_q  <= res_sec;
			out_nsec_q <= res_ns;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sec   = signed'(out_sec_q);
	assign out_nsec  = out_nsec_q;

endmodule

@@ src/uptime_and_realtime_keeper.sv @@
// Uptime and realtime keeper.
// Input channel (in_valid/in_ready) carries one item: action, sample_us, set_sec,
// set_nsec. Action 0 applies a microsecond counter sample, 1 reads uptime,
// 2 reads uptime plus the realtime offset, 3 sets the offset from set_sec/set_nsec.
// Output channel (out_valid/out_ready) returns exactly one item per input item,
// in order: out_sec/out_nsec.
// Path: the input register loads at the accepting edge, then five remainder stages and
// the result register follow; a stall on out_ready holds every stage.
// Throughput: one item per cycle while out_ready does not stall; set by the update of
// the uptime and offset registers in the last stage.
// Reset (arst_n low) clears uptime, sample history, second mark and offset to zero
// and empties the pipeline.
// A stall on out_ready freezes the whole pipeline; in_ready drops in the same
// cycle and picks up again as soon as the result item is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module uptime_and_realtime_keeper
	import ukp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [63:0]        sample_us,
	input  logic signed [63:0] set_sec,
	input  logic [29:0]        set_nsec,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] out_sec,
	output logic [29:0]        out_nsec
);

	// global advance: everything moves when the result register is free or drains
	logic        en;
	logic        vld_s1;
	action_t     action_s1;
	logic [63:0] sample_s1;
	logic [63:0] set_sec_s1;
	logic [29:0] set_nsec_s1;

	logic [63:0] diff;
	item_t       front_side;
	logic        rem_vld;
	logic [19:0] rem;
	item_t       rem_side;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1   <= action_t'(action);
			sample_s1   <= sample_us;
			set_sec_s1  <= unsigned'(set_sec);
			set_nsec_s1 <= set_nsec;
		end
	end

	// second mark, sample history and uptime seconds; produces the wrapped difference
	ukp_sample_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.item_valid (vld_s1),
		.action     (action_s1),
		.sample     (sample_s1),
		.set_sec    (set_sec_s1),
		.set_nsec   (set_nsec_s1),
		.diff       (diff),
		.side       (front_side)
	);

	// difference mod 10^6, pipelined
	ukp_mod_us u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.diff      (diff),
		.in_side   (front_side),
		.out_valid (rem_vld),
		.rem       (rem),
		.out_side  (rem_side)
	);

	// nanoseconds, offset and the result register
	ukp_time_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rem_vld),
		.rem       (rem),
		.side      (rem_side),
		.out_valid (out_valid),
		.out_sec   (out_sec),
		.out_nsec  (out_nsec)
	);

	`ASSERT_IMPLY(a_nsec_range, out_valid, out_nsec < NS_PER_SEC, "out_nsec not normalized")
	`ASSERT_IMPLY(a_rem_range, rem_vld, {44'b0, rem} < US_PER_SEC, "remainder out of range")
	`ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid && !out_ready, "stall without cause")
	`ASSERT_NEXT(a_result_kept, out_valid && !out_ready, out_valid, "result dropped on stall")

endmodule

@@ verif/tb_uptime_and_realtime_keeper.sv @@
`timescale 1ns / 1ps
module tb_uptime_and_realtime_keeper;
	import ukp_pkg::*;

	// Time constants for the local prediction, most held at 64 bits, the nanosecond limits at 30
	localparam logic [63:0] USEC_PER_SEC  = 64'd1000000;
	localparam logic [63:0] NSEC_PER_SEC  = 64'd1000000000;
	localparam logic [63:0] NSEC_PER_USEC = 64'd1000;
	localparam logic [63:0] SEC_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SEC_MIN       = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [29:0] NSEC_TOP      = 30'd999999999;
	localparam logic [29:0] NSEC_FIELD_MAX = 30'h3FFF_FFFF;
	localparam int          GAP_CAP       = 40;

	// One reported time value: seconds plus nanoseconds
	typedef struct {
		logic [63:0] sec;
		logic [29:0] nsec;
	} time_pair_t;

	// DUT ports; the inputs are at known values from time zero
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	action_t            action    = ACT_READ_UP;
	logic [63:0]        sample_us = '0;
	logic signed [63:0] set_sec   = '0;
	logic [29:0]        set_nsec  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [63:0] out_sec;
	logic [29:0]        out_nsec;

	// Shadow of the keeper state
	logic [63:0] up_sec;
	logic [29:0] up_nsec;
	logic [63:0] last_us;
	logic [63:0] second_mark;
	logic [63:0] rt_ofs_sec;
	logic [29:0] rt_ofs_nsec;

	// Times the block still owes, oldest first
	time_pair_t pending_times[$];

	// Idle percentages for the two sides, changed per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int errors      = 0;
	int results_ok  = 0;
	int n_samples   = 0;
	int n_up_reads  = 0;
	int n_rt_reads  = 0;
	int n_rt_sets   = 0;

	// Running microsecond counter for the random traffic
	logic [63:0] random_us = '0;

	uptime_and_realtime_keeper DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.sample_us (sample_us),
		.set_sec   (set_sec),
		.set_nsec  (set_nsec),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_sec   (out_sec),
		.out_nsec  (out_nsec)
	);

	always #10 clk = ~clk;

	// Hard stop in case the handshake hangs
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver side: drop ready at random per the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic reset_time_model();
		up_sec      = '0;
		up_nsec     = '0;
		last_us     = '0;
		second_mark = '0;
		rt_ofs_sec  = '0;
		rt_ofs_nsec = '0;
	endtask

	// Advance the shadow state by one item and return the time it reports
	task automatic compute_time(input action_t act, input logic [63:0] smp,
			input logic [63:0] ssec, input logic [29:0] snsec, output time_pair_t res);
		logic [63:0] diff;
		logic [63:0] ns;
		logic [63:0] rsec;
		logic [63:0] ss;
		logic [31:0] rns;
		logic [31:0] sns;
		case (act)
			ACT_SAMPLE: begin
				// mark is compared unsigned; it may have wrapped past zero
				if (smp >= second_mark) begin
					up_sec      = up_sec + 64'd1;
					second_mark = smp + USEC_PER_SEC;
				end
				// modular difference, so a counter wrap needs no special handling
				diff    = smp - last_us;
				ns      = {34'd0, up_nsec} + (diff % USEC_PER_SEC) * NSEC_PER_USEC;
				up_nsec = 30'(ns % NSEC_PER_SEC);
				last_us = smp;
				rsec    = up_sec;
				rns     = {2'b00, up_nsec};
			end
			ACT_READ_UP: begin
				rsec = up_sec;
				rns  = {2'b00, up_nsec};
			end
			ACT_READ_RT: begin
				rsec = up_sec + rt_ofs_sec;
				rns  = {2'b00, up_nsec} + {2'b00, rt_ofs_nsec};
				if (rns >= 32'(NSEC_PER_SEC)) begin
					rns  = rns - 32'(NSEC_PER_SEC);
					rsec = rsec + 64'd1;
				end
			end
			default: begin
				// nanoseconds above one second carry into the seconds first
				ss  = ssec;
				sns = {2'b00, snsec};
				if (sns >= 32'(NSEC_PER_SEC)) begin
					sns = sns - 32'(NSEC_PER_SEC);
					ss  = ss + 64'd1;
				end
				rsec = ss - up_sec;
				if (sns < {2'b00, up_nsec}) begin
					rns  = sns + 32'(NSEC_PER_SEC) - {2'b00, up_nsec};
					rsec = rsec - 64'd1;
				end else begin
					rns = sns - {2'b00, up_nsec};
				end
				rt_ofs_sec  = rsec;
				rt_ofs_nsec = rns[29:0];
			end
		endcase
		res.sec  = rsec;
		res.nsec = rns[29:0];
	endtask

	// Present one item, hold it until taken, then record what it should report.
	// Valid is only lowered for a gap before the item, so it never toggles within a step.
	task automatic send_item(input action_t act, input logic [63:0] smp,
			input logic [63:0] ssec, input logic [29:0] snsec);
		int gap;
		time_pair_t res;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < GAP_CAP)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		sample_us <= smp;
		set_sec   <= ssec;
		set_nsec  <= snsec;
		do @(posedge clk); while (!in_ready);
		compute_time(act, smp, ssec, snsec, res);
		pending_times.push_back(res);
		case (act)
			ACT_SAMPLE:  n_samples++;
			ACT_READ_UP: n_up_reads++;
			ACT_READ_RT: n_rt_reads++;
			default:     n_rt_sets++;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h (after %0d good results)",
			what, got, want, results_ok);
		errors++;
	endtask

	// Result checker: every taken item against the oldest expected time
	always @(posedge clk) begin
		time_pair_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_times.size() == 0) begin
				report_mismatch("unexpected result item", out_sec, '0);
			end else begin
				want = pending_times.pop_front();
				if (out_sec !== want.sec)
					report_mismatch("out_sec", out_sec, want.sec);
				else if (out_nsec !== want.nsec)
					report_mismatch("out_nsec", {34'd0, out_nsec}, {34'd0, want.nsec});
				else
					results_ok++;
			end
		end
	end

	// Reads straight out of reset: everything zero
	task automatic test_reset_state();
		send_item(ACT_READ_UP, '0, '0, '0);
		send_item(ACT_READ_RT, '0, '0, '0);
	endtask

	// First sample hits the zero mark; then just short of and exactly on the next mark
	task automatic test_second_mark();
		send_item(ACT_SAMPLE, 64'd0, '0, '0);
		send_item(ACT_SAMPLE, 64'd999999, '0, '0);
		send_item(ACT_SAMPLE, 64'd1000000, '0, '0);
		send_item(ACT_READ_UP, '0, '0, '0);
	endtask

	// Counter near the top, then wrapped past zero; also a half-range jump
	task automatic test_counter_wrap();
		send_item(ACT_SAMPLE, ALL_ONES - 64'd15, '0, '0);
		send_item(ACT_SAMPLE, 64'd5, '0, '0);
		send_item(ACT_SAMPLE, ALL_ONES, '0, '0);
		send_item(ACT_SAMPLE, SEC_MIN, '0, '0);
		send_item(ACT_SAMPLE, 64'd0, '0, '0);
	endtask

	// Offset set at the seconds extremes, with and without nanosecond carry
	task automatic test_realtime_offset();
		send_item(ACT_SET_RT, '0, '0, '0);
		send_item(ACT_SET_RT, '0, SEC_MAX, NSEC_TOP);
		send_item(ACT_READ_RT, '0, '0, '0);
		send_item(ACT_SET_RT, '0, SEC_MIN, 30'd0);
		send_item(ACT_READ_RT, '0, '0, '0);
		send_item(ACT_SET_RT, '0, ALL_ONES, NSEC_FIELD_MAX);
		send_item(ACT_READ_RT, '0, '0, '0);
		send_item(ACT_SET_RT, '0, SEC_MAX, 30'd1000000000);
		send_item(ACT_READ_RT, '0, '0, '0);
	endtask

	// Fields that the action does not use must not matter
	task automatic test_unused_fields();
		send_item(ACT_SAMPLE, 64'd2500000, ALL_ONES, NSEC_FIELD_MAX);
		send_item(ACT_READ_UP, ALL_ONES, ALL_ONES, NSEC_FIELD_MAX);
		send_item(ACT_READ_RT, ALL_ONES, SEC_MIN, NSEC_FIELD_MAX);
	endtask

	// Mostly a counter that moves forward by varied steps, with reads and offset
	// sets mixed in; random jumps, wraps and garbage in unused fields as noise.
	task automatic test_random_traffic(input int n_items);
		int pick;
		logic [63:0] step;
		logic [63:0] ssec;
		logic [29:0] snsec;
		action_t act;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			act  = (pick < 55) ? ACT_SAMPLE : (pick < 72) ? ACT_READ_UP :
				(pick < 88) ? ACT_READ_RT : ACT_SET_RT;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: step = 64'($urandom_range(0, 3000));
				4, 5:       step = 64'($urandom_range(999990, 1000010));
				6:          step = 64'($urandom_range(0, 5000000));
				7:          step = {$urandom, $urandom};
				8: begin
					random_us = ALL_ONES - 64'($urandom_range(0, 2000000));
					step      = '0;
				end
				default:    step = 64'($urandom_range(0, 1000000));
			endcase
			case ($urandom_range(0, 3))
				0:       ssec = 64'($urandom_range(0, 100000));
				1:       ssec = {$urandom, $urandom};
				2:       ssec = 64'd0 - 64'($urandom_range(0, 100000));
				default: begin
					case ($urandom_range(0, 2))
						0:       ssec = SEC_MAX;
						1:       ssec = SEC_MIN;
						default: ssec = ALL_ONES;
					endcase
				end
			endcase
			case ($urandom_range(0, 3))
				0:       snsec = 30'($urandom_range(0, 32'h3FFF_FFFF));
				1:       snsec = 30'($urandom_range(999999990, 1000000010));
				2:       snsec = 30'($urandom_range(0, 999999999));
				default: snsec = 30'($urandom);
			endcase
			if (act == ACT_SAMPLE) begin
				random_us = random_us + step;
				send_item(act, random_us, ssec, snsec);
			end else begin
				send_item(act, {$urandom, $urandom}, ssec, snsec);
			end
		end
	endtask

	initial begin
		reset_time_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender mostly busy, receiver mostly stalled
		send_idle_pct = 19;
		recv_idle_pct = 86;
		test_reset_state();
		test_second_mark();
		test_counter_wrap();
		test_realtime_offset();
		test_unused_fields();
		test_random_traffic(400);

		// Phase two: roles swapped
		send_idle_pct = 86;
		recv_idle_pct = 19;
		test_random_traffic(400);

		// Phase three: full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(400);

		in_valid <= 1'b0;
		while (pending_times.size() != 0) @(posedge clk);
		// a few pipeline depths more, so any stray result shows up
		repeat (30) @(posedge clk);

		$display("Sent %0d samples, %0d uptime reads, %0d realtime reads, %0d offset sets",
			n_samples, n_up_reads, n_rt_reads, n_rt_sets);
		$display("Checked %0d results under three idle mixes on both channels", results_ok);
		if (pending_times.size() != 0)
			report_mismatch("results never arrived", 64'(pending_times.size()), '0);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
